@@ src/wba_pkg.sv @@
// ----------------------------------------------------------------------------
// wba_pkg: shared types and constants for the windowed burst averager
// Field widths, register codes, the window struct and the queue entry.
// ----------------------------------------------------------------------------
package wba_pkg;

   localparam int BurstLenDefault = 21;
   localparam int SampleW         = 10;
   localparam int WinW            = 11;
   localparam int SumW            = 15;
   localparam int CountW          = 5;
   localparam int MeanW           = 10;
   localparam int QueueDepth      = 2;

   localparam logic signed [WinW-1:0] WindowLowReset  = -11'sd1;
   localparam logic        [WinW-1:0] WindowHighReset = 11'd1024;

   typedef enum logic [0:0] {
      CSR_WINDOW_LOW  = 1'b0,
      CSR_WINDOW_HIGH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [WinW-1:0] low;
      logic        [WinW-1:0] high;
   } window_type;

   typedef struct packed {
      logic [SumW-1:0]   sum;
      logic [CountW-1:0] count;
   } acc_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } back_state_type;

endpackage

@@ src/wba_if.sv @@
// ----------------------------------------------------------------------------
// wba_if: beat channels of the windowed burst averager
// Sample request channel and averaged response channel, valid/ready.
// ----------------------------------------------------------------------------
interface wba_req_if;
   logic                        valid;
   logic                        ready;
   logic [wba_pkg::SampleW-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [wba_pkg::MeanW-1:0]  mean_value;
   logic [wba_pkg::CountW-1:0] kept_count;

   modport source (output valid, output mean_value, output kept_count, input ready);
   modport sink   (input valid, input mean_value, input kept_count, output ready);
endinterface

@@ src/windowed_burst_averager.sv @@
// The result of a burst passes from the queue through the 15-step serial
// divider and then into the response register.
// Throughput: one sample beat per cycle; the last beat of a burst stalls intake
// while the two-entry queue is full, and the divider takes one total at a time.
// Reset (synchronous, active high) clears burst position, sums, queue and
// response valid, and returns the window to fully open.
// ----------------------------------------------------------------------------
// windowed_burst_averager: top level
// Window registers, sample intake, burst total queue and divider back end.
// ----------------------------------------------------------------------------
module windowed_burst_averager #(
   parameter int BURST_LEN = wba_pkg::BurstLenDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   wba_req_if.sink                req_bus,
   wba_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  wba_pkg::csr_index_type csr_index,
   input  logic [wba_pkg::WinW-1:0] csr_data
);
   import wba_pkg::*;

   window_type window_ff, window_in;
   logic       push_valid;
   acc_type    push_data;
   logic       queue_full;
   logic       pop_valid;
   logic       pop_ready;
   acc_type    pop_data;

   always_comb begin
      window_in = window_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LOW:  window_in.low  = $signed(csr_data);
            CSR_WINDOW_HIGH: window_in.high = csr_data;
            default: begin
               window_in = window_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.low  <= WindowLowReset;
         window_ff.high <= WindowHighReset;
      end else begin
         window_ff <= window_in;
      end
   end

   wba_front #(
      .BURST_LEN (BURST_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .window     (window_ff),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   wba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   wba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_bus)
   );

endmodule

@@ src/wba_front.sv @@
// ----------------------------------------------------------------------------
// wba_front: sample intake and accumulation
// Tracks burst position, filters samples by the window, sums kept samples
// and pushes the burst total into the queue on the last beat.
// ----------------------------------------------------------------------------
module wba_front #(
   parameter int BURST_LEN = wba_pkg::BurstLenDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  wba_pkg::window_type window,
   wba_req_if.sink             req,
   output logic                push_valid,
   output wba_pkg::acc_type    push_data,
   input  logic                queue_full
);
   import wba_pkg::*;

   localparam int PosW = $clog2(BURST_LEN);
   localparam logic [PosW-1:0] LastPos = PosW'(BURST_LEN - 1);

   logic [PosW-1:0]   pos_ff,   pos_in;
   logic [SumW-1:0]   sum_ff,   sum_in;
   logic [CountW-1:0] count_ff, count_in;

   logic              last;
   logic              fire;
   logic              keep;
   logic [SumW-1:0]   sum_new;
   logic [CountW-1:0] count_new;

   always_comb begin
      last      = (pos_ff == LastPos);
      req.ready = !(last && queue_full);
      fire      = req.valid && req.ready;
      keep      = (pos_ff != '0)
                  && ($signed({2'b00, req.sample}) > $signed({window.low[WinW-1], window.low}))
                  && ({1'b0, req.sample} < window.high);
      sum_new   = sum_ff + (keep ? SumW'(req.sample) : '0);
      count_new = count_ff + CountW'(keep);

      push_valid = fire && last;
      push_data  = '{sum: sum_new, count: count_new};

      pos_in   = pos_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (fire) begin
         if (last) begin
            pos_in   = '0;
            sum_in   = '0;
            count_in = '0;
         end else begin
            pos_in   = pos_ff + PosW'(1);
            sum_in   = sum_new;
            count_in = count_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/wba_queue.sv @@
// ----------------------------------------------------------------------------
// wba_queue: burst total queue
// Short first-in first-out buffer between the intake and the divider.
// ----------------------------------------------------------------------------
module wba_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  wba_pkg::acc_type push_data,
   output logic             full,
   input  logic             pop_ready,
   output logic             pop_valid,
   output wba_pkg::acc_type pop_data
);
   import wba_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int FillW = $clog2(QueueDepth + 1);

   acc_type            mem_ff [QueueDepth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0]   fill_ff,   fill_in;
   logic               push;
   logic               pop;

   always_comb begin
      full      = (fill_ff == FillW'(QueueDepth));
      pop_valid = (fill_ff != '0);
      pop_data  = mem_ff[rd_ptr_ff];
      push      = push_valid && !full;
      pop       = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      fill_in = fill_ff + FillW'(push) - FillW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ src/wba_back.sv @@
// ----------------------------------------------------------------------------
// wba_back: serial divider and response register
// Takes one burst total, divides sum by count one quotient bit per cycle
// and loads the mean into the response register.
// ----------------------------------------------------------------------------
module wba_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   input  wba_pkg::acc_type pop_data,
   output logic             pop_ready,
   wba_rsp_if.source        rsp
);
   import wba_pkg::*;

   localparam int StepW = $clog2(SumW);

   back_state_type     state_ff, state_in;
   logic [SumW-1:0]    quo_ff,   quo_in;
   logic [CountW-1:0]  rem_ff,   rem_in;
   logic [CountW-1:0]  div_ff,   div_in;
   logic [StepW-1:0]   step_ff,  step_in;
   logic               out_valid_ff, out_valid_in;
   logic [MeanW-1:0]   out_mean_ff,  out_mean_in;
   logic [CountW-1:0]  out_count_ff, out_count_in;

   logic [CountW:0]    trial;
   logic [CountW:0]    trial_diff;
   logic               trial_ge;
   logic               slot_free;

   always_comb begin
      trial      = {rem_ff, quo_ff[SumW-1]};
      trial_diff = trial - {1'b0, div_ff};
      trial_ge   = (trial >= {1'b0, div_ff});
      slot_free  = !out_valid_ff || rsp.ready;

      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      out_mean_in  = out_mean_ff;
      out_count_in = out_count_ff;
      out_valid_in = rsp.ready ? 1'b0 : out_valid_ff;
      pop_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               quo_in   = pop_data.sum;
               div_in   = pop_data.count;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            rem_in  = trial_ge ? trial_diff[CountW-1:0] : trial[CountW-1:0];
            quo_in  = {quo_ff[SumW-2:0], trial_ge};
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(SumW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_mean_in  = (div_ff == '0) ? '0 : quo_ff[MeanW-1:0];
               out_count_in = div_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp.valid      = out_valid_ff;
      rsp.mean_value = out_mean_ff;
      rsp.kept_count = out_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      step_ff      <= step_in;
      out_mean_ff  <= out_mean_in;
      out_count_ff <= out_count_in;
   end

endmodule

@@ src/wba_checker.sv @@
// ----------------------------------------------------------------------------
// wba_checker: port-level checks for the windowed burst averager
// Watches the response channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module wba_checker #(
   parameter int BURST_LEN = wba_pkg::BurstLenDefault
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [wba_pkg::MeanW-1:0]  rsp_mean_value,
   input logic [wba_pkg::CountW-1:0] rsp_kept_count
);
   import wba_pkg::*;

   a_no_beat_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mean_value) && $stable(rsp_kept_count))
      else $error("response payload changed while stalled");

   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kept_count == '0) |-> (rsp_mean_value == '0))
      else $error("nonzero mean with no kept samples");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_kept_count} <= (CountW + 1)'(BURST_LEN - 1)))
      else $error("kept count exceeds samples per burst");

endmodule

bind windowed_burst_averager wba_checker #(
   .BURST_LEN (BURST_LEN)
) u_wba_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_mean_value (rsp_bus.mean_value),
   .rsp_kept_count (rsp_bus.kept_count)
);

@@ test/windowed_burst_averager_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_burst_averager_tb: self-checking bench for the burst averager
// Streams bursts of converter samples under a series of window settings,
// from fully open through single-value and crossed windows, and checks each
// burst mean and kept count against an in-bench running-sum predictor.
// Both channels idle at random, and the response side holds off for long
// stretches so that the burst queue fills and sample intake stalls.
// ----------------------------------------------------------------------------
module windowed_burst_averager_tb;
   import wba_pkg::*;

   localparam int BurstLen      = BurstLenDefault;
   localparam int BurstsPerSet  = 6;
   localparam int SettleCycles  = 40;
   localparam int CycleLimit    = 200000;
   localparam int LongHoldCycles = 300;

   typedef struct {
      logic [MeanW-1:0]  mean_value;
      logic [CountW-1:0] kept_count;
   } burst_average_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [WinW-1:0] csr_data;

   wba_req_if req_if ();
   wba_rsp_if rsp_if ();

   windowed_burst_averager u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // window as the block sees it, plus the running burst totals
   window_type        active_window;
   logic [4:0]        burst_pos;
   logic [SumW-1:0]   burst_sum;
   logic [CountW-1:0] burst_kept;

   logic [SampleW-1:0] pending_samples[$];
   burst_average_type  expected_averages[$];
   int samples_queued = 0;
   int samples_taken  = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   logic req_took = 1'b0;

   int send_left = 0;
   int gap_left  = 0;
   int ready_run_left = 0;
   int hold_left  = 0;
   int holds_done = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic average_sample(input logic [SampleW-1:0] s);
      burst_average_type done;
      if (burst_pos != 0 && int'(s) > int'(active_window.low) &&
          int'(s) < int'(active_window.high)) begin
         burst_sum  = burst_sum + s;
         burst_kept = burst_kept + 1'b1;
      end
      if (int'(burst_pos) + 1 >= BurstLen) begin
         done.kept_count = burst_kept;
         done.mean_value = (burst_kept == 0) ? '0 : MeanW'(burst_sum / burst_kept);
         expected_averages.push_back(done);
         burst_pos  = '0;
         burst_sum  = '0;
         burst_kept = '0;
      end else begin
         burst_pos = burst_pos + 1'b1;
      end
   endtask

   // monitor: check response beats, then predict from sample beats
   always @(posedge clock) begin
      burst_average_type due;
      if (reset) begin
         burst_pos  = '0;
         burst_sum  = '0;
         burst_kept = '0;
         req_took <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_averages.size() == 0) begin
               $error("unexpected beat: mean_value=%0d kept_count=%0d",
                      rsp_if.mean_value, rsp_if.kept_count);
               error_count++;
            end else begin
               due = expected_averages.pop_front();
               if (rsp_if.mean_value !== due.mean_value) begin
                  $error("mean_value: expected %0d, actual %0d",
                         due.mean_value, rsp_if.mean_value);
                  error_count++;
               end
               if (rsp_if.kept_count !== due.kept_count) begin
                  $error("kept_count: expected %0d, actual %0d",
                         due.kept_count, rsp_if.kept_count);
                  error_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            average_sample(req_if.sample);
            samples_taken++;
         end
         req_took <= req_if.valid && req_if.ready;
      end
   end

   // driver: bursts of beats with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_took) begin
         // hold the beat until taken
      end else if (gap_left > 0) begin
         req_if.valid <= 1'b0;
         gap_left--;
      end else if (pending_samples.size() > 0) begin
         req_if.sample <= pending_samples.pop_front();
         req_if.valid  <= 1'b1;
         if (send_left <= 1) begin
            send_left = $urandom_range(1, 40);
            gap_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            send_left--;
         end
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // receiver: random stall pattern, plus long hold-offs while samples pile up
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (holds_done < 2 && pending_samples.size() > 100 &&
                   (holds_done == 0 || cycle_count > 2500)) begin
         rsp_if.ready <= 1'b0;
         hold_left = LongHoldCycles;
         holds_done++;
      end else if (ready_run_left > 0) begin
         ready_run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_if.ready <= 1'b0;
         ready_run_left = $urandom_range(1, 20);
      end else begin
         rsp_if.ready <= 1'b1;
         ready_run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 30);
      end
   end

   function automatic logic [SampleW-1:0] draw_sample();
      int lo;
      int hi;
      int v;
      lo = int'(active_window.low) + 1;
      hi = int'(active_window.high) - 1;
      case ($urandom_range(0, 9))
         4, 5, 6: begin
            if (lo < 0) lo = 0;
            if (hi > 1023) hi = 1023;
            v = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(0, 1023);
         end
         7: begin
            case ($urandom_range(0, 3))
               0: v = lo - 1;
               1: v = lo;
               2: v = hi;
               default: v = hi + 1;
            endcase
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
         end
         8: v = $urandom_range(0, 1) ? 1023 : 0;
         default: v = $urandom_range(0, 1023);
      endcase
      return SampleW'(v);
   endfunction

   task automatic queue_sample(input logic [SampleW-1:0] s);
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   task automatic wait_quiet();
      while (samples_taken != samples_queued || expected_averages.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_window(input logic [WinW-1:0] low, input logic [WinW-1:0] high);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WINDOW_LOW;
      csr_data  <= low;
      active_window.low = low;
      @(negedge clock);
      csr_index <= CSR_WINDOW_HIGH;
      csr_data  <= high;
      active_window.high = high;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   logic [WinW-1:0] window_lows[13] = '{11'h7FF, 11'h400, 11'd100, 11'd1023, 11'd511,
      11'd1022, 11'h7FF, 11'd600, 11'h400, 11'd1023, 11'd0, 11'd0, 11'd0};
   logic [WinW-1:0] window_highs[13] = '{11'd1024, 11'd2047, 11'd900, 11'd0, 11'd513,
      11'd2047, 11'd1, 11'd600, 11'd0, 11'd2047, 11'd0, 11'd0, 11'd0};
   logic [SampleW-1:0] opening_burst[BurstLen] = '{10'd1023, 10'd0, 10'd1023, 10'h155,
      10'h2AA, 10'd1, 10'd512, 10'd511, 10'd1022, 10'd2, 10'd256, 10'd768, 10'd128,
      10'd896, 10'd64, 10'd960, 10'd1000, 10'd23, 10'd700, 10'd300, 10'd999};

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_WINDOW_LOW;
      csr_data      = '0;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      rsp_if.ready  = 1'b0;
      active_window.low  = WindowLowReset;
      active_window.high = WindowHighReset;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window: first sample dropped, the rest averaged
      foreach (opening_burst[i]) queue_sample(opening_burst[i]);
      wait_quiet();

      for (int set = 0; set < 13; set++) begin
         if (set >= 10)
            write_window(WinW'($urandom_range(0, 2047)), WinW'($urandom_range(0, 2047)));
         else
            write_window(window_lows[set], window_highs[set]);
         for (int n = 0; n < BurstsPerSet * BurstLen; n++) queue_sample(draw_sample());
         wait_quiet();
      end

      if (error_count == 0 && expected_averages.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
